FILE: hdl/rmse_accumulator_4lane_defines.svh
// ----------------------------------------------------------------------------
// rmse accumulator assertion macros
// shared property forms for the checker of the four-lane rmse accumulator
// ----------------------------------------------------------------------------
`ifndef RMSE_ACCUMULATOR_4LANE_DEFINES_SVH
`define RMSE_ACCUMULATOR_4LANE_DEFINES_SVH

// same-cycle implication
`define RMSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rmse accumulator: same-cycle check failed");

// next-cycle implication
`define RMSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rmse accumulator: next-cycle check failed");

`endif

FILE: hdl/rmse_acc_pkg.sv
// ----------------------------------------------------------------------------
// rmse accumulator package
// word types and fixed widths shared by the lanes, the root unit and the top
// ----------------------------------------------------------------------------
`default_nettype none

package rmse_acc_pkg;

    localparam int LANES  = 4;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 25;
    localparam int SQ_W   = 2 * IN_W;
    localparam int SUM_W  = 63;
    localparam int ROOT_W = 32;

    typedef logic signed [IN_W-1:0] t_coord;
    typedef logic [SUM_W-1:0]       t_sum;
    typedef logic [OUT_W-1:0]       t_rmse;

    typedef struct packed {
        logic signed [IN_W-1:0] est_px;
        logic signed [IN_W-1:0] est_py;
        logic signed [IN_W-1:0] est_vx;
        logic signed [IN_W-1:0] est_vy;
        logic signed [IN_W-1:0] true_px;
        logic signed [IN_W-1:0] true_py;
        logic signed [IN_W-1:0] true_vx;
        logic signed [IN_W-1:0] true_vy;
        logic                   last_pair;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] rmse_px;
        logic [OUT_W-1:0] rmse_py;
        logic [OUT_W-1:0] rmse_vx;
        logic [OUT_W-1:0] rmse_vy;
        logic             saturated;
    } t_out;

    typedef struct packed {
        logic start;
        logic clear;
    } t_lane_ctl;

endpackage

`default_nettype wire

FILE: hdl/rmse_acc_lane.sv
// ----------------------------------------------------------------------------
// rmse accumulator lane
// difference, registered square and saturating square-sum for one component
// ----------------------------------------------------------------------------
`default_nettype none

module rmse_acc_lane (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_clear,
    input  wire rmse_acc_pkg::t_coord i_est,
    input  wire rmse_acc_pkg::t_coord i_true,
    output rmse_acc_pkg::t_sum        o_sum,
    output logic                      o_clip
);
    import rmse_acc_pkg::*;

    logic signed [IN_W:0] w_diff;
    logic signed [IN_W:0] w_neg;
    logic [IN_W-1:0]      w_mag;
    logic [SUM_W:0]       w_add;
    logic [SQ_W-1:0]      r_sq;
    logic                 r_en;
    t_sum                 r_sum;

    assign w_diff = {i_est[IN_W-1], i_est} - {i_true[IN_W-1], i_true};
    assign w_neg  = -w_diff;
    assign w_mag  = w_diff[IN_W] ? w_neg[IN_W-1:0] : w_diff[IN_W-1:0];
    assign w_add  = {1'b0, r_sum} + (SUM_W+1)'(r_sq);
    assign o_clip = r_en & w_add[SUM_W];
    assign o_sum  = r_sum;

    always_ff @(posedge i_clk) begin
        r_sq <= SQ_W'(w_mag) * SQ_W'(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b0;
            r_sum <= '0;
        end else begin
            r_en <= i_en;
            if (i_clear) begin
                r_sum <= '0;
            end else if (r_en) begin
                r_sum <= w_add[SUM_W] ? '1 : w_add[SUM_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rmse_acc_dsq.sv
// ----------------------------------------------------------------------------
// rmse accumulator divide and root unit
// restoring divide of a lane sum by the count, then digit-by-digit floor root
// ----------------------------------------------------------------------------
`default_nettype none

module rmse_acc_dsq #(
    parameter int CW = 13
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire rmse_acc_pkg::t_sum i_sum,
    input  wire logic [CW-1:0]      i_div,
    output logic                    o_done,
    output rmse_acc_pkg::t_rmse     o_root
);
    import rmse_acc_pkg::*;

    localparam int NUM_W  = 2 * ROOT_W;
    localparam int SR_W   = ROOT_W + 4;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SQRT = 2'd2;

    logic [1:0]        r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_done;
    logic [NUM_W-1:0]  r_num;
    logic [CW-1:0]     r_den;
    logic [CW-1:0]     r_rem;
    logic [SR_W-1:0]   r_srem;
    logic [ROOT_W-1:0] r_root;

    logic [CW:0]       w_dsh;
    logic [CW:0]       w_dsub;
    logic              w_dge;
    logic [SR_W-1:0]   w_ssh;
    logic [SR_W-1:0]   w_trial;
    logic              w_sge;

    assign w_dsh   = {r_rem, r_num[SUM_W-1]};
    assign w_dge   = w_dsh >= {1'b0, r_den};
    assign w_dsub  = w_dsh - {1'b0, r_den};
    assign w_ssh   = {r_srem[SR_W-3:0], r_num[NUM_W-1:NUM_W-2]};
    assign w_trial = SR_W'({r_root, 2'b01});
    assign w_sge   = w_ssh >= w_trial;

    assign o_done = r_done;
    assign o_root = r_root[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DIV;
                        r_step  <= '0;
                    end
                end
                S_DIV: begin
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= S_SQRT;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (r_step == STEP_W'(ROOT_W - 1)) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_num  <= NUM_W'(i_sum);
            r_den  <= i_div;
            r_rem  <= '0;
            r_srem <= '0;
            r_root <= '0;
        end else if (r_state == S_DIV) begin
            r_rem              <= w_dge ? w_dsub[CW-1:0] : w_dsh[CW-1:0];
            r_num[SUM_W-1:0]   <= {r_num[SUM_W-2:0], w_dge};
        end else if (r_state == S_SQRT) begin
            r_srem <= w_sge ? (w_ssh - w_trial) : w_ssh;
            r_root <= {r_root[ROOT_W-2:0], w_sge};
            r_num  <= {r_num[NUM_W-3:0], 2'b00};
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rmse_accumulator_4lane.sv
// ----------------------------------------------------------------------------
// rmse accumulator, four lanes
// running root-mean-square error of a four-component estimate against truth
//
//   channel | direction | payload | handshake
//   --------+-----------+---------+------------------
//   input   | in        | i_in    | i_valid / o_stall
//   result  | out       | o_out   | o_valid / i_stall
//
// one pair word per cycle while a run accumulates (square, then add)
// a last word stalls the input until the result is worked out by the
// one-bit-a-cycle divider and the two-bit-a-cycle root unit
// the result word sits in an output register; a new run may fill meanwhile,
// but its last word waits at the divide until that register is taken
// synchronous reset clears the sums, the count and the saturation flag
// ----------------------------------------------------------------------------
`default_nettype none

module rmse_accumulator_4lane #(
    parameter int MAX_PAIRS = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire rmse_acc_pkg::t_in i_in,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output rmse_acc_pkg::t_out     o_out
);
    import rmse_acc_pkg::*;

    localparam int             CW      = $clog2(MAX_PAIRS + 1);
    localparam logic [CW-1:0]  CNT_MAX = CW'(MAX_PAIRS);

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;
    localparam logic [1:0] ST_CALC  = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CW-1:0]    r_count;
    logic             r_ovf;
    logic             r_oval;
    t_out             r_out;

    logic             w_acc;
    logic             w_keep;
    logic             w_lane_en;
    logic             w_fin;
    t_lane_ctl        w_ctl;
    t_coord           w_est  [LANES];
    t_coord           w_true [LANES];
    t_sum             w_sum  [LANES];
    t_rmse            w_root [LANES];
    logic [LANES-1:0] w_clip;
    logic [LANES-1:0] w_done;

    assign o_stall   = (r_state != ST_RUN);
    assign w_acc     = i_valid & ~o_stall;
    assign w_keep    = (r_count != CNT_MAX);
    assign w_lane_en = w_acc & w_keep;
    assign w_fin     = (r_state == ST_CALC) & (&w_done);

    assign w_ctl.start = (r_state == ST_START) & ~r_oval;
    assign w_ctl.clear = w_fin;

    assign w_est[0]  = i_in.est_px;
    assign w_est[1]  = i_in.est_py;
    assign w_est[2]  = i_in.est_vx;
    assign w_est[3]  = i_in.est_vy;
    assign w_true[0] = i_in.true_px;
    assign w_true[1] = i_in.true_py;
    assign w_true[2] = i_in.true_vx;
    assign w_true[3] = i_in.true_vy;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        rmse_acc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_lane_en),
            .i_clear (w_ctl.clear),
            .i_est   (w_est[g]),
            .i_true  (w_true[g]),
            .o_sum   (w_sum[g]),
            .o_clip  (w_clip[g])
        );

        rmse_acc_dsq #(
            .CW (CW)
        ) u_dsq (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_ctl.start),
            .i_sum   (w_sum[g]),
            .i_div   (r_count),
            .o_done  (w_done[g]),
            .o_root  (w_root[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (w_acc && i_in.last_pair) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_START;
            end
            ST_START: begin
                if (w_ctl.start) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (w_fin) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                if (w_lane_en) begin
                    r_count <= r_count + 1'b1;
                end
                if ((w_acc && !w_keep) || (|w_clip)) begin
                    r_ovf <= 1'b1;
                end
            end
            if (w_fin) begin
                r_oval <= 1'b1;
            end else if (r_oval && !i_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    // merge the lane roots into one result word
    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_out.rmse_px   <= w_root[0];
            r_out.rmse_py   <= w_root[1];
            r_out.rmse_vx   <= w_root[2];
            r_out.rmse_vy   <= w_root[3];
            r_out.saturated <= r_ovf;
        end
    end

    assign o_valid = r_oval;
    assign o_out   = r_out;

endmodule

`default_nettype wire

FILE: hdl/rmse_acc_chk.sv
// ----------------------------------------------------------------------------
// rmse accumulator checker
// port-level properties of the four-lane rmse accumulator, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "rmse_accumulator_4lane_defines.svh"

module rmse_acc_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire rmse_acc_pkg::t_in  i_in,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire rmse_acc_pkg::t_out o_out
);
    import rmse_acc_pkg::*;

    // a stalled result word holds
    `RMSE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out))

    // the last word of a run closes the input while the result is worked out
    `RMSE_ASSERT_NXT(a_stall_after_last, i_clk, i_rst_n, i_valid && !o_stall && i_in.last_pair, o_stall)

    // without saturation every root stays below 2^24
    `RMSE_ASSERT_IMP(a_rmse_range, i_clk, i_rst_n, o_valid && !o_out.saturated, !o_out.rmse_px[OUT_W-1] && !o_out.rmse_py[OUT_W-1] && !o_out.rmse_vx[OUT_W-1] && !o_out.rmse_vy[OUT_W-1])

endmodule

bind rmse_accumulator_4lane rmse_acc_chk u_rmse_acc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_in    (i_in),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);

`default_nettype wire
